>>> design/mlvf_pkg.sv
// Shared types and constants of the mean least variance filter.
`default_nettype none

package mlvf_pkg;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HALF_WIDTH = 2;
    localparam int DEF_PIXEL_BITS     = 8;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int WIDTH_BITS      = 11;
    localparam int HEIGHT_BITS     = 16;
    localparam int HALF_BITS       = 2;
    localparam int PIXEL_PORT_BITS = 8;
    // offsets inside the window, wide enough for twice the largest half width
    localparam int IDX_BITS        = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_index_t CFG_HALF_WIDTH   = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [HALF_BITS-1:0]   RST_HALF_WIDTH   = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_ACC_WAIT,
        ST_INJECT,
        ST_SEL_WAIT,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic                accept;
        logic                issue;
        logic [IDX_BITS-1:0] row_off;
        logic [IDX_BITS-1:0] col_off;
        logic                first;
        logic                last;
        logic                inject;
        logic                div_start;
        logic                out_load;
        logic                advance;
    } dp_cmd_t;

    typedef struct packed {
        logic                due;
        logic [IDX_BITS-1:0] span;
        logic                sel_busy;
        logic                div_done;
        logic                out_full;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/mlvf_ctrl.sv
// Sequencer of the mean least variance filter.
`default_nettype none

module mlvf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mlvf_pkg::dp_status_t status,
    output mlvf_pkg::dp_cmd_t    cmd
);
    import mlvf_pkg::*;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   row_reg, row_next;
    logic [IDX_BITS-1:0]   col_reg, col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue   = 1'b1;
                cmd.row_off = row_reg;
                cmd.col_off = col_reg;
                cmd.first   = (row_reg == '0) && (col_reg == '0);
                cmd.last    = (row_reg == status.span) && (col_reg == status.span);
                if (col_reg == status.span)
                begin
                    col_next = '0;
                    if (row_reg == status.span)
                        state_next = ST_ACC_WAIT;
                    else
                        row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_ACC_WAIT:
            begin
                state_next = ST_INJECT;
            end
            ST_INJECT:
            begin
                cmd.inject = 1'b1;
                state_next = ST_SEL_WAIT;
            end
            ST_SEL_WAIT:
            begin
                if (!status.sel_busy)
                begin
                    if (status.due)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done && !status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/mlvf_datapath.sv
// Datapath: line store, window statistics, least variance selection, divider, output register.
`default_nettype none

module mlvf_datapath #(
    parameter int MAX_WIDTH      = mlvf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HALF_WIDTH = mlvf_pkg::DEF_MAX_HALF_WIDTH,
    parameter int PIXEL_BITS     = mlvf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mlvf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlvf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [mlvf_pkg::PIXEL_PORT_BITS-1:0] pixel,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [mlvf_pkg::PIXEL_PORT_BITS-1:0] filtered_pixel,
    output logic                                 last_of_frame,
    input  mlvf_pkg::dp_cmd_t                    cmd,
    output mlvf_pkg::dp_status_t                 status
);
    import mlvf_pkg::*;

    localparam int RING     = 2 * MAX_HALF_WIDTH + 1;
    localparam int EXT_COLS = MAX_WIDTH + 2 * MAX_HALF_WIDTH;
    localparam int SQ       = RING * RING;
    localparam int NB       = $clog2(SQ + 1);
    localparam int S1B      = PIXEL_BITS + NB;
    localparam int S2B      = 2 * PIXEL_BITS + NB;
    localparam int STB      = NB + S1B + S2B;
    localparam int NUMB     = 2 * S1B;
    localparam int DENB     = 2 * NB;
    localparam int PRODB    = NUMB + DENB;
    localparam int DPRODB   = S1B + NB;
    localparam int RB       = $clog2(RING);
    localparam int CB       = $clog2(MAX_WIDTH);
    localparam int XB       = $clog2(EXT_COLS);
    localparam int YB       = HEIGHT_BITS + 1;
    localparam int WB       = $clog2(MAX_WIDTH + 1);
    localparam int QCB      = $clog2(PIXEL_BITS + 1);
    localparam int IN_USED  = (PIXEL_BITS < PIXEL_PORT_BITS) ? PIXEL_BITS : PIXEL_PORT_BITS;

    // configuration and frame position
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [HALF_BITS-1:0]   half_reg;
    logic [XB-1:0]          cx_reg;
    logic [YB-1:0]          cy_reg;
    logic [RB-1:0]          cy_mod_reg;

    logic [WB-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [HALF_BITS-1:0]   hw_eff;
    logic [IDX_BITS-1:0]    hw2;
    logic [XB:0]            ew;
    logic [YB:0]            eh;
    logic [XB:0]            cx_inc;
    logic [YB:0]            cy_inc;
    logic                   due;
    logic                   frame_last;
    logic                   cfg_hit;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WB'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        h_eff  = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
        hw_eff = (32'(half_reg) > MAX_HALF_WIDTH) ? HALF_BITS'(MAX_HALF_WIDTH) : half_reg;
    end

    assign hw2        = IDX_BITS'({hw_eff, 1'b0});
    assign ew         = (XB + 1)'(w_eff) + (XB + 1)'(hw2);
    assign eh         = (YB + 1)'(h_eff) + (YB + 1)'(hw2);
    assign cx_inc     = (XB + 1)'(cx_reg) + (XB + 1)'(1);
    assign cy_inc     = (YB + 1)'(cy_reg) + (YB + 1)'(1);
    assign due        = (32'(cx_reg) >= 32'(hw2)) && (32'(cy_reg) >= 32'(hw2));
    assign frame_last = (cx_inc == ew) && (cy_inc == eh);
    assign cfg_hit    = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                   (cfg_index == CFG_IMAGE_HEIGHT) ||
                                   (cfg_index == CFG_HALF_WIDTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            half_reg   <= RST_HALF_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                CFG_HALF_WIDTH:   half_reg   <= cfg_data[HALF_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cy_mod_reg <= '0;
        end
        else if (cfg_hit)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cy_mod_reg <= '0;
        end
        else if (cmd.advance)
        begin
            if (cx_inc >= ew)
            begin
                cx_reg <= '0;
                if (cy_inc >= eh)
                begin
                    cy_reg     <= '0;
                    cy_mod_reg <= '0;
                end
                else
                begin
                    cy_reg     <= YB'(cy_inc);
                    cy_mod_reg <= (32'(cy_mod_reg) == RING - 1) ? '0 : cy_mod_reg + 1'b1;
                end
            end
            else
            begin
                cx_reg <= XB'(cx_inc);
            end
        end
    end

    // element address inside the window
    logic [YB:0]   rsum;
    logic [XB:0]   csum;
    logic [XB:0]   col_idx;
    logic          row_ok;
    logic          col_ok;
    logic [RB+1:0] rr;
    logic [RB-1:0] ring_idx;

    always_comb
    begin
        rsum     = (YB + 1)'(cy_reg) + (YB + 1)'(cmd.row_off);
        csum     = (XB + 1)'(cx_reg) + (XB + 1)'(cmd.col_off);
        col_idx  = csum - (XB + 1)'(hw2);
        row_ok   = (rsum >= (YB + 1)'(hw2)) &&
                   ((rsum - (YB + 1)'(hw2)) < (YB + 1)'(h_eff));
        col_ok   = (csum >= (XB + 1)'(hw2)) && (col_idx < (XB + 1)'(w_eff));
        rr       = (RB + 2)'(cy_mod_reg) + (RB + 2)'(RING) - (RB + 2)'(hw2)
                   + (RB + 2)'(cmd.row_off);
        ring_idx = (32'(rr) >= RING) ? RB'(rr - (RB + 2)'(RING)) : RB'(rr);
    end

    // line store and statistics store
    logic [PIXEL_BITS-1:0] pix_mem  [RING][MAX_WIDTH];
    logic [STB-1:0]        stat_mem [RING][EXT_COLS];
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] pix_q;
    logic [STB-1:0]        stat_q;
    logic                  pix_we;
    logic [NB-1:0]         acc_n_reg;
    logic [S1B-1:0]        acc_s1_reg;
    logic [S2B-1:0]        acc_s2_reg;

    assign pix_in = PIXEL_BITS'(pixel[IN_USED-1:0]);
    assign pix_we = cmd.accept && (32'(cx_reg) < 32'(w_eff)) && (32'(cy_reg) < 32'(h_eff));

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[cy_mod_reg][cx_reg[CB-1:0]] <= pix_in;
        pix_q <= pix_mem[ring_idx][col_idx[CB-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.inject)
            stat_mem[cy_mod_reg][cx_reg] <= {acc_n_reg, acc_s1_reg, acc_s2_reg};
        stat_q <= stat_mem[ring_idx][col_idx[XB-1:0]];
    end

    // read stage flags
    logic                  s1_acc_v_reg;
    logic                  s1_sel_v_reg;
    logic                  s1_first_reg;
    logic [PIXEL_BITS-1:0] ref_reg;
    logic [PIXEL_BITS-1:0] ref_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_acc_v_reg <= 1'b0;
            s1_sel_v_reg <= 1'b0;
            s1_first_reg <= 1'b0;
        end
        else
        begin
            s1_acc_v_reg <= cmd.issue && row_ok && col_ok;
            s1_sel_v_reg <= cmd.issue && due && !cmd.last;
            s1_first_reg <= cmd.issue && cmd.first;
        end
    end

    assign ref_cur = s1_first_reg ? pix_q : ref_reg;

    always_ff @(posedge clk)
    begin
        if (s1_first_reg)
            ref_reg <= pix_q;
    end

    // window statistics accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_n_reg  <= '0;
            acc_s1_reg <= '0;
            acc_s2_reg <= '0;
        end
        else if (s1_acc_v_reg)
        begin
            acc_n_reg  <= acc_n_reg + 1'b1;
            acc_s1_reg <= acc_s1_reg + S1B'(pix_q);
            acc_s2_reg <= acc_s2_reg + S2B'(pix_q * pix_q);
        end
    end

    // selection stage A: products
    logic           sel_v_in;
    logic [NB-1:0]  in_n;
    logic [S1B-1:0] in_s1;
    logic [S2B-1:0] in_s2;

    always_comb
    begin
        if (cmd.inject)
        begin
            sel_v_in = due;
            in_n     = acc_n_reg;
            in_s1    = acc_s1_reg;
            in_s2    = acc_s2_reg;
        end
        else
        begin
            sel_v_in = s1_sel_v_reg;
            {in_n, in_s1, in_s2} = stat_q;
        end
    end

    logic                     a_v_reg;
    logic [NB-1:0]            a_n_reg;
    logic [S1B-1:0]           a_s1_reg;
    logic [NUMB-1:0]          a_ns2_reg;
    logic [NUMB-1:0]          a_s1sq_reg;
    logic [DENB-1:0]          a_nn1_reg;
    logic [S1B-1:0]           a_refn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= sel_v_in;
    end

    always_ff @(posedge clk)
    begin
        a_n_reg    <= in_n;
        a_s1_reg   <= in_s1;
        a_ns2_reg  <= NUMB'(in_n * in_s2);
        a_s1sq_reg <= NUMB'(in_s1 * in_s1);
        a_nn1_reg  <= DENB'(in_n * (in_n - 1'b1));
        a_refn_reg <= S1B'(ref_cur * in_n);
    end

    // selection stage B: variance fraction and distance to the original pixel
    logic             b_v_reg;
    logic [NB-1:0]    b_n_reg;
    logic [S1B-1:0]   b_s1_reg;
    logic [NUMB-1:0]  b_num_reg;
    logic [DENB-1:0]  b_den_reg;
    logic [S1B-1:0]   b_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        b_n_reg  <= a_n_reg;
        b_s1_reg <= a_s1_reg;
        if (32'(a_n_reg) > 1)
        begin
            b_num_reg <= a_ns2_reg - a_s1sq_reg;
            b_den_reg <= a_nn1_reg;
        end
        else
        begin
            b_num_reg <= '0;
            b_den_reg <= DENB'(1);
        end
        b_dist_reg <= (a_s1_reg >= a_refn_reg) ? a_s1_reg - a_refn_reg
                                               : a_refn_reg - a_s1_reg;
    end

    // selection stage C: running best by cross-multiplication
    logic              best_v_reg;
    logic [NUMB-1:0]   best_num_reg;
    logic [DENB-1:0]   best_den_reg;
    logic [NB-1:0]     best_n_reg;
    logic [S1B-1:0]    best_s1_reg;
    logic [S1B-1:0]    best_dist_reg;
    logic [PRODB-1:0]  p_new;
    logic [PRODB-1:0]  p_best;
    logic [DPRODB-1:0] d_new;
    logic [DPRODB-1:0] d_best;
    logic              take;

    always_comb
    begin
        p_new  = PRODB'(b_num_reg * best_den_reg);
        p_best = PRODB'(best_num_reg * b_den_reg);
        d_new  = DPRODB'(b_dist_reg * best_n_reg);
        d_best = DPRODB'(best_dist_reg * b_n_reg);
        take   = !best_v_reg || (p_new < p_best) || ((p_new == p_best) && (d_new < d_best));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_v_reg <= 1'b0;
        else if (cmd.accept)
            best_v_reg <= 1'b0;
        else if (b_v_reg)
            best_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (b_v_reg && take)
        begin
            best_num_reg  <= b_num_reg;
            best_den_reg  <= b_den_reg;
            best_n_reg    <= b_n_reg;
            best_s1_reg   <= b_s1_reg;
            best_dist_reg <= b_dist_reg;
        end
    end

    // restoring divider for the mean, one quotient bit a cycle
    logic                  div_busy_reg;
    logic [QCB-1:0]        div_cnt_reg;
    logic [NB-1:0]         div_rem_reg;
    logic [PIXEL_BITS-1:0] div_q_reg;
    logic [NB:0]           trial;
    logic                  trial_ge;

    assign trial    = {div_rem_reg, div_q_reg[PIXEL_BITS-1]};
    assign trial_ge = trial >= (NB + 1)'(best_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= QCB'(PIXEL_BITS);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg  <= div_cnt_reg - 1'b1;
            div_busy_reg <= (div_cnt_reg != QCB'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_rem_reg <= NB'(best_s1_reg >> PIXEL_BITS);
            div_q_reg   <= best_s1_reg[PIXEL_BITS-1:0];
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= trial_ge ? NB'(trial - (NB + 1)'(best_n_reg)) : NB'(trial);
            div_q_reg   <= PIXEL_BITS'({div_q_reg, trial_ge});
        end
    end

    // output register
    logic                              out_full_reg;
    logic [PIXEL_PORT_BITS-1:0]        out_pix_reg;
    logic                              out_last_reg;
    logic [PIXEL_BITS-1:0]             mean;

    assign mean = (best_n_reg == '0) ? '0 : div_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (cmd.out_load)
            out_full_reg <= 1'b1;
        else if (out_ready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pix_reg  <= PIXEL_PORT_BITS'(mean);
            out_last_reg <= frame_last;
        end
    end

    assign out_valid      = out_full_reg;
    assign filtered_pixel = out_pix_reg;
    assign last_of_frame  = out_last_reg;

    always_comb
    begin
        status.due      = due;
        status.span     = hw2;
        status.sel_busy = s1_sel_v_reg || a_v_reg || b_v_reg;
        status.div_done = !div_busy_reg;
        status.out_full = out_full_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> !out_full_reg)
        else $error("result loaded over an untaken result");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> best_n_reg != '0)
        else $error("chosen window holds no pixel");
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.div_start |-> !(s1_sel_v_reg || a_v_reg || b_v_reg))
        else $error("divider started before selection drained");
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.accept |-> !div_busy_reg && !a_v_reg && !b_v_reg)
        else $error("item accepted while previous one in flight");

endmodule

`default_nettype wire

>>> design/mean_least_variance_filter_core.sv
// Top level of the mean least variance filter: sequencer and datapath.
// An item is accepted only in the idle state, so a new transfer waits until the previous
// one is done; the pace is set by the window element sweep over the line and statistics
// stores plus the bit-serial mean divider, which items without a result skip, and is slower
// while a finished result waits in the output register.
// Reset clears position and control state and loads 640 x 480, half width 1.
`default_nettype none

module mean_least_variance_filter_core #(
    parameter int MAX_WIDTH      = mlvf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HALF_WIDTH = mlvf_pkg::DEF_MAX_HALF_WIDTH,
    parameter int PIXEL_BITS     = mlvf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mlvf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlvf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [mlvf_pkg::PIXEL_PORT_BITS-1:0] pixel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mlvf_pkg::PIXEL_PORT_BITS-1:0] filtered_pixel,
    output logic                                 last_of_frame
);
    import mlvf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // the frame position alone decides the role of a transfer; kind is informative
    logic unused_kind;
    assign unused_kind = kind;

    mlvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mlvf_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel          (pixel),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .filtered_pixel (filtered_pixel),
        .last_of_frame  (last_of_frame),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for mean_least_variance_filter_core: random frames, exact prediction.
`default_nettype none

module testbench;
    import mlvf_pkg::*;

    localparam int RING = 5;
    localparam int LINE = 1024;
    localparam int EXT  = LINE + 4;
    localparam int CYCLE_LIMIT = 2000000;

    class mlvf_scoreboard;
        bit [7:0]        line_pix[RING][LINE];
        longint unsigned win_n[RING][EXT];
        longint unsigned win_s1[RING][EXT];
        longint unsigned win_s2[RING][EXT];
        int unsigned     reg_width, reg_height, reg_half;
        int unsigned     col, row;
        bit [8:0]        filtered_q[$];
        int              errors;
        int              results;

        function new();
            reg_width  = 640;
            reg_height = 480;
            reg_half   = 1;
            col        = 0;
            row        = 0;
            errors     = 0;
            results    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, bit [15:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  reg_width  = data[10:0];
                CFG_IMAGE_HEIGHT: reg_height = data;
                CFG_HALF_WIDTH:   reg_half   = data[1:0];
                default:          return;
            endcase
            col = 0;
            row = 0;
        endfunction

        // variance fraction of a window: num/den, zero for one element or none
        function void var_of(int r, int c, output longint unsigned num,
                             output longint unsigned den);
            if (win_n[r][c] > 1) begin
                num = win_n[r][c] * win_s2[r][c] - win_s1[r][c] * win_s1[r][c];
                den = win_n[r][c] * (win_n[r][c] - 1);
            end
            else begin
                num = 0;
                den = 1;
            end
        endfunction

        function longint unsigned dist_of(int r, int c, longint unsigned ref_pix);
            longint unsigned t;
            t = ref_pix * win_n[r][c];
            return (win_s1[r][c] >= t) ? win_s1[r][c] - t : t - win_s1[r][c];
        endfunction

        function void note_input(bit k, bit [7:0] p);
            int unsigned w, h, hw, ew, eh, x, y;
            longint unsigned n, s1, s2, v, ref_pix, num, den, bnum, bden;
            int br, bc, rr, cc;
            bit found;
            w  = (reg_width == 0) ? 1 : (reg_width > LINE ? LINE : reg_width);
            h  = (reg_height == 0) ? 1 : reg_height;
            hw = (reg_half > 2) ? 2 : reg_half;
            ew = w + 2 * hw;
            eh = h + 2 * hw;
            if (col < w && row < h)
                line_pix[row % RING][col] = p;
            n = 0; s1 = 0; s2 = 0;
            for (int r = int'(row) - int'(2 * hw); r <= int'(row); r++) begin
                if (r < 0 || r >= int'(h)) continue;
                for (int c = int'(col) - int'(2 * hw); c <= int'(col); c++) begin
                    if (c < 0 || c >= int'(w)) continue;
                    v = line_pix[r % RING][c];
                    n++; s1 += v; s2 += v * v;
                end
            end
            win_n[row % RING][col]  = n;
            win_s1[row % RING][col] = s1;
            win_s2[row % RING][col] = s2;
            if (col >= 2 * hw && row >= 2 * hw) begin
                x = col - 2 * hw;
                y = row - 2 * hw;
                ref_pix = line_pix[y % RING][x];
                found = 0; bnum = 0; bden = 1; br = 0; bc = 0;
                for (int unsigned iy = y; iy <= y + 2 * hw; iy++)
                    for (int unsigned ix = x; ix <= x + 2 * hw; ix++) begin
                        rr = iy % RING;
                        cc = ix;
                        var_of(rr, cc, num, den);
                        if (!found || num * bden < bnum * den) begin
                            found = 1; br = rr; bc = cc; bnum = num; bden = den;
                        end
                        else if (num * bden == bnum * den &&
                                 dist_of(rr, cc, ref_pix) * win_n[br][bc] <
                                 dist_of(br, bc, ref_pix) * win_n[rr][cc]) begin
                            br = rr; bc = cc; bnum = num; bden = den;
                        end
                    end
                v = (win_n[br][bc] != 0) ? win_s1[br][bc] / win_n[br][bc] : 0;
                filtered_q.push_back({(x == w - 1 && y == h - 1), v[7:0]});
            end
            col++;
            if (col >= ew) begin
                col = 0;
                row++;
                if (row >= eh) row = 0;
            end
        endfunction

        function void check_result(bit [7:0] fp, bit lf);
            bit [8:0] exp_res;
            results++;
            if (filtered_q.size() == 0) begin
                $error("unexpected result: filtered_pixel %0d last_of_frame %0d", fp, lf);
                errors++;
                return;
            end
            exp_res = filtered_q.pop_front();
            if (fp !== exp_res[7:0]) begin
                $error("filtered_pixel: expected %0d, got %0d", exp_res[7:0], fp);
                errors++;
            end
            if (lf !== exp_res[8]) begin
                $error("last_of_frame: expected %0d, got %0d", exp_res[8], lf);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       kind;
    logic [PIXEL_PORT_BITS-1:0] pixel;
    logic                       out_valid;
    logic                       out_ready;
    logic [PIXEL_PORT_BITS-1:0] filtered_pixel;
    logic                       last_of_frame;

    mlvf_scoreboard sb;
    int             items_sent;
    int             cycles;

    mean_least_variance_filter_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .pixel          (pixel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_pixel (filtered_pixel),
        .last_of_frame  (last_of_frame)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("mean_least_variance_filter_core: mismatch");
                $finish;
            end
        end
    end

    // receiver: short random stalls, calm stretches, one long hold-off
    initial
    begin
        int  hold;
        bit  long_done;
        hold = 0;
        long_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(filtered_pixel, last_of_frame);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!long_done && sb.results >= 60)
            begin
                long_done = 1;
                hold = 600;
                out_ready <= 1'b0;
            end
            else if ((sb.results / 100) % 3 != 1 && $urandom_range(7) == 0)
            begin
                hold = ($urandom_range(15) == 0) ? $urandom_range(60, 20)
                                                 : $urandom_range(3, 1);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send(bit k, bit [7:0] p);
        int gap;
        in_valid <= 1'b1;
        kind     <= k;
        pixel    <= p;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(k, p);
        items_sent++;
        if ((items_sent / 150) % 4 == 2)
            gap = 0;
        else if ($urandom_range(3) != 0)
            gap = 0;
        else
            gap = ($urandom_range(12) == 0) ? $urandom_range(50, 10) : $urandom_range(3, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.filtered_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_regs(bit [15:0] w, bit [15:0] h, bit [15:0] hw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_HALF_WIDTH;
        cfg_data  <= hw;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(CFG_IMAGE_WIDTH, w);
        sb.write_reg(CFG_IMAGE_HEIGHT, h);
        sb.write_reg(CFG_HALF_WIDTH, hw);
        @(posedge clk);
    endtask

    // mode 0 uniform, 1 near-flat, 2 extremes, 3 alternating 0/255
    task automatic run_phase(int w, int h, int hw, int ticks, int mode, bit pause_mid);
        int unsigned ew, ew_eff, hw_eff, w_eff, h_eff, c, r, base;
        bit [7:0] p;
        bit k;
        w_eff  = (w == 0) ? 1 : (w > LINE ? LINE : w);
        h_eff  = (h == 0) ? 1 : h;
        hw_eff = (hw > 2) ? 2 : hw;
        ew     = w_eff + 2 * hw_eff;
        base   = $urandom_range(254);
        set_regs(w, h, hw);
        for (int i = 0; i < ticks; i++)
        begin
            c = i % ew;
            r = (i / ew) % (h_eff + 2 * hw_eff);
            k = !(c < w_eff && r < h_eff);
            if ($urandom_range(9) == 0)
                k = ~k;
            case (mode)
                0:       p = $urandom();
                1:       p = base + $urandom_range(1);
                2:       p = $urandom_range(1) ? 8'hff : 8'h00;
                default: p = (i % 2) ? 8'hff : 8'h00;
            endcase
            if (pause_mid && i == ticks / 2)
                drain();
            send(k, p);
        end
        drain();
    endtask

    initial
    begin
        int w, h, hw, frames, ticks;
        sb = new();
        items_sent = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        kind      <= 1'b0;
        pixel     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_phase(3, 3, 1, 25, 3, 0);
        run_phase(1, 1, 0, 3, 2, 0);
        run_phase(1, 1, 2, 25, 0, 0);
        run_phase(0, 0, 3, 25, 1, 0);
        run_phase(2047, 1, 0, 120, 0, 0);
        run_phase(1024, 2, 2, 60, 0, 0);
        run_phase(5, 65535, 2, 90, 0, 0);

        while (items_sent < 1550)
        begin
            w  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            h  = $urandom_range(8, 1);
            hw = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
            frames = $urandom_range(2, 1);
            if (hw > 2)
                ticks = frames * (w + 4) * (h + 4);
            else
                ticks = frames * (w + 2 * hw) * (h + 2 * hw);
            // the final phase stops near the item budget, possibly mid-frame
            if (ticks > 1560 - items_sent)
                ticks = 1560 - items_sent;
            if (hw > 2)
                run_phase(w, h, hw, ticks, $urandom_range(2), 0);
            else
                run_phase(w, h, hw, ticks, $urandom_range(2), items_sent < 400);
        end

        drain();
        if (sb.errors == 0 && sb.filtered_q.size() == 0)
            $display("mean_least_variance_filter_core: match");
        else
            $display("mean_least_variance_filter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/mlvf_pkg.sv
design/mlvf_ctrl.sv
design/mlvf_datapath.sv
design/mean_least_variance_filter_core.sv
tb/testbench.sv
